// ===== rtl/core/allfl_pkg.sv =====
// Package for the array linked list core: request, status, state and selector codes, the
// command and status structs between controller and datapath, and the default store size.
// No dependencies.
`default_nettype none

package allfl_pkg;

    // Default number of slots in the node store.
    localparam int SLOTS_DEF = 8;

    typedef enum logic [1:0] {
        REQ_INS_FRONT = 2'd0,
        REQ_INS_LAST  = 2'd1,
        REQ_DELETE    = 2'd2,
        REQ_WALK      = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TAKE,
        S_APP_WALK,
        S_DEL_CHK,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_DONE,
        S_FULL,
        S_NFOUND,
        S_EMPTY,
        S_WALK
    } t_state;

    typedef enum logic [1:0] {
        RD_FREE,
        RD_HEAD,
        RD_LINK
    } t_rd_src;

    typedef enum logic [1:0] {
        WA_FREE,
        WA_CUR,
        WA_PREV
    } t_wa_src;

    typedef enum logic [2:0] {
        WD_HEAD,
        WD_NIL,
        WD_SLOT,
        WD_LINK,
        WD_FREE
    } t_wd_src;

    typedef enum logic {
        CUR_HEAD,
        CUR_LINK
    } t_cur_src;

    typedef enum logic {
        SLOT_FREE,
        SLOT_CUR
    } t_slot_src;

    typedef enum logic {
        FREE_LINK,
        FREE_CUR
    } t_free_src;

    typedef enum logic {
        HEAD_FREE,
        HEAD_LINK
    } t_head_src;

    typedef enum logic [2:0] {
        OUT_FULL,
        OUT_NFOUND,
        OUT_EMPTY,
        OUT_DONE,
        OUT_WALK
    } t_out_kind;

    typedef struct packed {
        logic      load_req;
        logic      rd_en;
        t_rd_src   rd_src;
        logic      lnk_we;
        logic      val_we;
        t_wa_src   wa_src;
        t_wd_src   wd_src;
        logic      cur_ld;
        t_cur_src  cur_src;
        logic      prev_clr;
        logic      prev_ld;
        logic      slot_ld;
        t_slot_src slot_src;
        logic      free_ld;
        t_free_src free_src;
        logic      head_ld;
        t_head_src head_src;
        logic      out_ld;
        t_out_kind out_kind;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic free_ok;
        logic head_ok;
        logic link_ok;
        logic match;
        logic prev_ok;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/array_linked_list_with_free_list_core.sv =====
// Singly linked list of bytes over a slot store with a free list.
// Channels: request in (i_in_valid / o_in_stall, fields i_req_type and
// i_item_value), results out (o_out_valid / i_out_stall). A beat moves on an
// edge where valid is high and stall is low.
// One request is worked at a time. An insert reads the free slot and S_TAKE
// stores the node; an append then follows the links to the tail in S_APP_WALK.
// A delete reads the head, S_DEL_CHK compares node by node, then S_DEL_UNLINK
// and S_DEL_FREE return the slot. A walk reads the head and S_WALK gives one
// result per node. The link walk does one registered store read per cycle,
// holding while a walk result waits; a new request beat is taken on the cycle
// after the final result is loaded.
// A walk gives one result per node, last flag on the final one; every other
// request gives one result. A result waits in the output register while the
// receiver stalls; the walk then holds on its current node.
// Reset (synchronous, active low) empties the list, chains all slots on the free
// list and drops any pending result. It needs no clearing pass.
// Uses allfl_pkg, allfl_ctrl and allfl_dpath.
`default_nettype none

module array_linked_list_with_free_list_core #(
    parameter int SLOTS = allfl_pkg::SLOTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_item_value,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_status,
    output logic [7:0]      o_out_value,
    output logic [2:0]      o_slot_index,
    output logic            o_last_flag
);

    allfl_pkg::t_cmd  w_cmd;
    allfl_pkg::t_stat w_stat;

    allfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    allfl_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_req_type   (i_req_type),
        .i_item_value (i_item_value),
        .i_out_stall  (i_out_stall),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_out_value  (o_out_value),
        .o_slot_index (o_slot_index),
        .o_last_flag  (o_last_flag)
    );

`ifndef SYNTH
    // A result is never written over one that the receiver has not yet taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_ld |-> (!o_out_valid || !i_out_stall))
        else $error("output register loaded while a result is still pending");

    // A request beat is followed by a busy cycle: one request at a time.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while the previous one is in progress");

    // While a result without the last flag is pending, the walk is still running.
    a_walk_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_flag) |-> o_in_stall)
        else $error("controller idle with an unfinished walk");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/allfl_dpath.sv =====
// Datapath of the array linked list core: node value and link stores, list and
// free-list pointers, walk cursors and the output register. Uses allfl_pkg.
`default_nettype none

module allfl_dpath #(
    parameter int SLOTS = allfl_pkg::SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire allfl_pkg::t_cmd  i_cmd,
    input  wire logic [1:0]       i_req_type,
    input  wire logic [7:0]       i_item_value,
    input  wire logic             i_out_stall,
    output allfl_pkg::t_stat      o_stat,
    output logic                  o_out_valid,
    output logic [1:0]            o_status,
    output logic [7:0]            o_out_value,
    output logic [2:0]            o_slot_index,
    output logic                  o_last_flag
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    allfl_pkg::t_req   r_req;
    logic [7:0]        r_val;
    logic [LINK_W-1:0] r_head;
    logic [LINK_W-1:0] r_free;
    logic [LINK_W-1:0] r_cur;
    logic [LINK_W-1:0] r_prev;
    logic [LINK_W-1:0] r_slot;
    logic [SLOTS-1:0]  r_lvld;

    logic [7:0]        mem_val  [SLOTS];
    logic [LINK_W-1:0] mem_link [SLOTS];

    logic [7:0]        r_rd_val;
    logic [LINK_W-1:0] r_rd_link;
    logic              r_rd_lv;
    logic [IDX_W-1:0]  r_rd_addr;

    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [7:0]        r_out_value;
    logic [2:0]        r_out_slot;
    logic              r_out_last;

    logic [LINK_W-1:0] link_rd;
    logic [LINK_W-1:0] rd_ptr;
    logic [LINK_W-1:0] wr_ptr;
    logic [LINK_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W+2:0] slot_ext;
    logic [LINK_W+2:0] cur_ext;
    logic              out_free;

    // A link entry never written still holds its reset value: slot i links to i+1,
    // which for the last slot is the null link.
    assign link_rd = r_rd_lv ? r_rd_link : (LINK_W'(r_rd_addr) + LINK_W'(1));

    always_comb begin
        case (i_cmd.rd_src)
            allfl_pkg::RD_FREE: rd_ptr = r_free;
            allfl_pkg::RD_HEAD: rd_ptr = r_head;
            allfl_pkg::RD_LINK: rd_ptr = link_rd;
            default:            rd_ptr = link_rd;
        endcase
        case (i_cmd.wa_src)
            allfl_pkg::WA_FREE: wr_ptr = r_free;
            allfl_pkg::WA_CUR:  wr_ptr = r_cur;
            allfl_pkg::WA_PREV: wr_ptr = r_prev;
            default:            wr_ptr = r_cur;
        endcase
        case (i_cmd.wd_src)
            allfl_pkg::WD_HEAD: wr_data = r_head;
            allfl_pkg::WD_NIL:  wr_data = NIL;
            allfl_pkg::WD_SLOT: wr_data = r_slot;
            allfl_pkg::WD_LINK: wr_data = link_rd;
            allfl_pkg::WD_FREE: wr_data = r_free;
            default:            wr_data = NIL;
        endcase
    end

    assign rd_addr  = rd_ptr[IDX_W-1:0];
    assign wr_addr  = wr_ptr[IDX_W-1:0];
    assign slot_ext = {3'b000, r_slot};
    assign cur_ext  = {3'b000, r_cur};
    assign out_free = !r_out_valid || !i_out_stall;

    // Node stores: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.val_we) begin
            mem_val[wr_addr] <= r_val;
        end
        if (i_cmd.lnk_we) begin
            mem_link[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_val  <= mem_val[rd_addr];
            r_rd_link <= mem_link[rd_addr];
            r_rd_lv   <= r_lvld[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld <= '0;
            r_head <= NIL;
            r_free <= '0;
        end else begin
            if (i_cmd.lnk_we) begin
                r_lvld[wr_addr] <= 1'b1;
            end
            if (i_cmd.head_ld) begin
                r_head <= (i_cmd.head_src == allfl_pkg::HEAD_FREE) ? r_free : link_rd;
            end
            if (i_cmd.free_ld) begin
                r_free <= (i_cmd.free_src == allfl_pkg::FREE_LINK) ? link_rd : r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= allfl_pkg::t_req'(i_req_type);
            r_val <= i_item_value;
        end
        if (i_cmd.cur_ld) begin
            r_cur <= (i_cmd.cur_src == allfl_pkg::CUR_HEAD) ? r_head : link_rd;
        end
        if (i_cmd.prev_clr) begin
            r_prev <= NIL;
        end else if (i_cmd.prev_ld) begin
            r_prev <= r_cur;
        end
        if (i_cmd.slot_ld) begin
            r_slot <= (i_cmd.slot_src == allfl_pkg::SLOT_FREE) ? r_free : r_cur;
        end
    end

    // Output register: the controller loads it only when it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            case (i_cmd.out_kind)
                allfl_pkg::OUT_FULL: begin
                    r_out_status <= allfl_pkg::ST_FULL;
                    r_out_value  <= r_val;
                    r_out_slot   <= 3'd0;
                    r_out_last   <= 1'b1;
                end
                allfl_pkg::OUT_NFOUND: begin
                    r_out_status <= allfl_pkg::ST_NOT_FOUND;
                    r_out_value  <= r_val;
                    r_out_slot   <= 3'd0;
                    r_out_last   <= 1'b1;
                end
                allfl_pkg::OUT_EMPTY: begin
                    r_out_status <= allfl_pkg::ST_EMPTY;
                    r_out_value  <= 8'd0;
                    r_out_slot   <= 3'd0;
                    r_out_last   <= 1'b1;
                end
                allfl_pkg::OUT_DONE: begin
                    r_out_status <= allfl_pkg::ST_OK;
                    r_out_value  <= r_val;
                    r_out_slot   <= slot_ext[2:0];
                    r_out_last   <= 1'b1;
                end
                allfl_pkg::OUT_WALK: begin
                    r_out_status <= allfl_pkg::ST_OK;
                    r_out_value  <= r_rd_val;
                    r_out_slot   <= cur_ext[2:0];
                    r_out_last   <= !(link_rd < NIL);
                end
                default: begin
                    r_out_status <= allfl_pkg::ST_OK;
                    r_out_value  <= r_val;
                    r_out_slot   <= 3'd0;
                    r_out_last   <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.req      = r_req;
        o_stat.free_ok  = r_free < NIL;
        o_stat.head_ok  = r_head < NIL;
        o_stat.link_ok  = link_rd < NIL;
        o_stat.match    = r_rd_val == r_val;
        o_stat.prev_ok  = r_prev < NIL;
        o_stat.out_free = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_out_value  = r_out_value;
    assign o_slot_index = r_out_slot;
    assign o_last_flag  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/allfl_ctrl.sv =====
// Controller of the array linked list core: the request state machine that
// steers the datapath through commands. Uses allfl_pkg.
`default_nettype none

module allfl_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire allfl_pkg::t_stat i_stat,
    output logic                  o_in_stall,
    output allfl_pkg::t_cmd       o_cmd
);

    allfl_pkg::t_state r_state;
    allfl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= allfl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            allfl_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = allfl_pkg::S_DECODE;
                end
            end
            allfl_pkg::S_DECODE: begin
                case (i_stat.req)
                    allfl_pkg::REQ_INS_FRONT, allfl_pkg::REQ_INS_LAST: begin
                        if (i_stat.free_ok) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_src = allfl_pkg::RD_FREE;
                            n_state      = allfl_pkg::S_TAKE;
                        end else begin
                            n_state = allfl_pkg::S_FULL;
                        end
                    end
                    allfl_pkg::REQ_DELETE: begin
                        if (i_stat.head_ok) begin
                            o_cmd.rd_en    = 1'b1;
                            o_cmd.rd_src   = allfl_pkg::RD_HEAD;
                            o_cmd.cur_ld   = 1'b1;
                            o_cmd.cur_src  = allfl_pkg::CUR_HEAD;
                            o_cmd.prev_clr = 1'b1;
                            n_state        = allfl_pkg::S_DEL_CHK;
                        end else begin
                            n_state = allfl_pkg::S_NFOUND;
                        end
                    end
                    allfl_pkg::REQ_WALK: begin
                        if (i_stat.head_ok) begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_src  = allfl_pkg::RD_HEAD;
                            o_cmd.cur_ld  = 1'b1;
                            o_cmd.cur_src = allfl_pkg::CUR_HEAD;
                            n_state       = allfl_pkg::S_WALK;
                        end else begin
                            n_state = allfl_pkg::S_EMPTY;
                        end
                    end
                    default: begin
                        n_state = allfl_pkg::S_IDLE;
                    end
                endcase
            end
            allfl_pkg::S_TAKE: begin
                // The free slot's link is now read: store the value, unhook the slot
                // from the free list and give it its new link.
                o_cmd.val_we   = 1'b1;
                o_cmd.lnk_we   = 1'b1;
                o_cmd.wa_src   = allfl_pkg::WA_FREE;
                o_cmd.wd_src   = (i_stat.req == allfl_pkg::REQ_INS_FRONT) ?
                                 allfl_pkg::WD_HEAD : allfl_pkg::WD_NIL;
                o_cmd.slot_ld  = 1'b1;
                o_cmd.slot_src = allfl_pkg::SLOT_FREE;
                o_cmd.free_ld  = 1'b1;
                o_cmd.free_src = allfl_pkg::FREE_LINK;
                if (i_stat.req == allfl_pkg::REQ_INS_FRONT || !i_stat.head_ok) begin
                    o_cmd.head_ld  = 1'b1;
                    o_cmd.head_src = allfl_pkg::HEAD_FREE;
                    n_state        = allfl_pkg::S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_src  = allfl_pkg::RD_HEAD;
                    o_cmd.cur_ld  = 1'b1;
                    o_cmd.cur_src = allfl_pkg::CUR_HEAD;
                    n_state       = allfl_pkg::S_APP_WALK;
                end
            end
            allfl_pkg::S_APP_WALK: begin
                if (i_stat.link_ok) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_src  = allfl_pkg::RD_LINK;
                    o_cmd.cur_ld  = 1'b1;
                    o_cmd.cur_src = allfl_pkg::CUR_LINK;
                end else begin
                    o_cmd.lnk_we = 1'b1;
                    o_cmd.wa_src = allfl_pkg::WA_CUR;
                    o_cmd.wd_src = allfl_pkg::WD_SLOT;
                    n_state      = allfl_pkg::S_DONE;
                end
            end
            allfl_pkg::S_DEL_CHK: begin
                if (i_stat.match) begin
                    n_state = allfl_pkg::S_DEL_UNLINK;
                end else if (i_stat.link_ok) begin
                    o_cmd.prev_ld = 1'b1;
                    o_cmd.cur_ld  = 1'b1;
                    o_cmd.cur_src = allfl_pkg::CUR_LINK;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_src  = allfl_pkg::RD_LINK;
                end else begin
                    n_state = allfl_pkg::S_NFOUND;
                end
            end
            allfl_pkg::S_DEL_UNLINK: begin
                if (i_stat.prev_ok) begin
                    o_cmd.lnk_we = 1'b1;
                    o_cmd.wa_src = allfl_pkg::WA_PREV;
                    o_cmd.wd_src = allfl_pkg::WD_LINK;
                end else begin
                    o_cmd.head_ld  = 1'b1;
                    o_cmd.head_src = allfl_pkg::HEAD_LINK;
                end
                n_state = allfl_pkg::S_DEL_FREE;
            end
            allfl_pkg::S_DEL_FREE: begin
                o_cmd.lnk_we   = 1'b1;
                o_cmd.wa_src   = allfl_pkg::WA_CUR;
                o_cmd.wd_src   = allfl_pkg::WD_FREE;
                o_cmd.free_ld  = 1'b1;
                o_cmd.free_src = allfl_pkg::FREE_CUR;
                o_cmd.slot_ld  = 1'b1;
                o_cmd.slot_src = allfl_pkg::SLOT_CUR;
                n_state        = allfl_pkg::S_DONE;
            end
            allfl_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = allfl_pkg::OUT_DONE;
                    n_state        = allfl_pkg::S_IDLE;
                end
            end
            allfl_pkg::S_FULL: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = allfl_pkg::OUT_FULL;
                    n_state        = allfl_pkg::S_IDLE;
                end
            end
            allfl_pkg::S_NFOUND: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = allfl_pkg::OUT_NFOUND;
                    n_state        = allfl_pkg::S_IDLE;
                end
            end
            allfl_pkg::S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = allfl_pkg::OUT_EMPTY;
                    n_state        = allfl_pkg::S_IDLE;
                end
            end
            allfl_pkg::S_WALK: begin
                // The read data stays put while the output is blocked, so the same
                // node is offered again on the next cycle.
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = allfl_pkg::OUT_WALK;
                    if (i_stat.link_ok) begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_src  = allfl_pkg::RD_LINK;
                        o_cmd.cur_ld  = 1'b1;
                        o_cmd.cur_src = allfl_pkg::CUR_LINK;
                    end else begin
                        n_state = allfl_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = allfl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
